/* rtl/core/sxfr_pkg.sv */
// shared types and constants for the sync xor frame receiver
package sxfr_pkg;

   // byte that opens every frame
   localparam logic [7:0] SYNC_BYTE = 8'haa;

   // number of body bytes carried in a report (frame bytes 1..6)
   localparam int NUM_BODY = 6;

   // depth of the queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 2;

   // frame status codes
   localparam logic [1:0] ST_GOOD  = 2'd0;
   localparam logic [1:0] ST_BAD   = 2'd1;
   localparam logic [1:0] ST_TRUNC = 2'd2;

   typedef logic [7:0] byte_type;

   // one frame report as it travels from front to back
   typedef struct packed {
      byte_type [NUM_BODY-1:0] body;
      byte_type                check;
      logic [1:0]              status;
   } report_type;

endpackage

/* rtl/core/sync_xor_frame_receiver.sv */
// top level of the sync xor frame receiver
// throughput: one byte request per cycle, sustained while the report queue has room
// a report passes from the front end into the queue, then into the output register that drives rsp_ ports
// the front end pushes its report combinationally from the byte; a stalled response side holds it back
// reset: synchronous, active high; clears frame state, queue pointers and rsp_valid
module sync_xor_frame_receiver #(
   parameter int FRAME_LEN = 8
) (
   input  logic       clock,
   input  logic       reset,
   // byte request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   // frame report channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_header_byte,
   output logic [7:0] rsp_sequence_byte,
   output logic [7:0] rsp_device_id,
   output logic [7:0] rsp_command_byte,
   output logic [7:0] rsp_param_low,
   output logic [7:0] rsp_param_high,
   output logic [7:0] rsp_check_byte,
   output logic [1:0] rsp_frame_status
);

   // handshake between the parts
   logic                 accept;
   logic                 push;
   sxfr_pkg::report_type push_item;
   logic                 q_full;
   logic                 q_pop;
   logic                 q_not_empty;
   sxfr_pkg::report_type q_item;
   sxfr_pkg::report_type out_item;

   // hold off requests whenever the queue cannot take a report
   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // front end tracks the open frame and builds reports
   sxfr_front #(
      .FRAME_LEN (FRAME_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (accept),
      .byte_data  (req_rx_byte),
      .push       (push),
      .push_item  (push_item)
   );

   // decouples the front end from a stalled response side
   sxfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_item  (q_item)
   );

   // output register drives the report channel
   sxfr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_item    (out_item)
   );

   // body bytes in frame order: header first
   assign rsp_header_byte   = out_item.body[0];
   assign rsp_sequence_byte = out_item.body[1];
   assign rsp_device_id     = out_item.body[2];
   assign rsp_command_byte  = out_item.body[3];
   assign rsp_param_low     = out_item.body[4];
   assign rsp_param_high    = out_item.body[5];
   assign rsp_check_byte    = out_item.check;
   assign rsp_frame_status  = out_item.status;

endmodule

/* rtl/core/sxfr_front.sv */
// front end: frame tracking, running xor and report generation
module sxfr_front #(
   parameter int FRAME_LEN = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  byte_valid,
   input  logic [7:0]            byte_data,
   output logic                  push,
   output sxfr_pkg::report_type  push_item
);

   localparam int STORE_LEN = FRAME_LEN - 1;
   localparam int IW        = $clog2(FRAME_LEN);
   localparam logic [IW-1:0] STORE_LAST = IW'(STORE_LEN);

   logic                  open_ff, open_in;
   logic [IW-1:0]         index_ff, index_in;
   logic [7:0]            xor_ff, xor_in;
   sxfr_pkg::byte_type [sxfr_pkg::NUM_BODY-1:0] body_ff;

   logic is_sync;
   logic storing;
   logic closing;

   assign is_sync = (byte_data == sxfr_pkg::SYNC_BYTE);
   assign storing = byte_valid && !is_sync && open_ff && (index_ff < STORE_LAST);
   assign closing = byte_valid && !is_sync && open_ff && (index_ff >= STORE_LAST);

   always_comb begin
      open_in  = open_ff;
      index_in = index_ff;
      xor_in   = xor_ff;
      if (byte_valid && is_sync) begin
         open_in  = 1'b1;
         index_in = IW'(1);
         xor_in   = sxfr_pkg::SYNC_BYTE;
      end else if (storing) begin
         index_in = index_ff + IW'(1);
         xor_in   = xor_ff ^ byte_data;
      end else if (closing) begin
         open_in  = 1'b0;
         index_in = '0;
         xor_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= 1'b0;
         index_ff <= '0;
         xor_ff   <= '0;
      end else begin
         open_ff  <= open_in;
         index_ff <= index_in;
         xor_ff   <= xor_in;
      end
   end

   // body bytes kept only for the reported positions; others stay zero
   always_ff @(posedge clock) begin
      for (int k = 0; k < sxfr_pkg::NUM_BODY; k++) begin
         if (reset || (k + 1 >= STORE_LEN)) begin
            body_ff[k] <= '0;
         end else if ((byte_valid && is_sync) || closing) begin
            body_ff[k] <= '0;
         end else if (storing && (index_ff == IW'(k + 1))) begin
            body_ff[k] <= byte_data;
         end
      end
   end

   // report on a sync inside an open frame or on the check byte
   assign push = (byte_valid && is_sync && open_ff) || closing;

   always_comb begin
      push_item.body = body_ff;
      if (is_sync) begin
         push_item.check  = '0;
         push_item.status = sxfr_pkg::ST_TRUNC;
      end else begin
         push_item.check  = byte_data;
         push_item.status = (xor_ff == byte_data) ? sxfr_pkg::ST_GOOD : sxfr_pkg::ST_BAD;
      end
   end

endmodule

/* rtl/core/sxfr_queue.sv */
// short report queue between front and back
module sxfr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sxfr_pkg::report_type  push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output sxfr_pkg::report_type  pop_item
);

   localparam int DEPTH = sxfr_pkg::QUEUE_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   sxfr_pkg::report_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   logic do_push;
   logic do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/core/sxfr_back.sv */
// back end: output register that presents reports on the response channel
module sxfr_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_not_empty,
   input  sxfr_pkg::report_type  q_item,
   output logic                  q_pop,
   output logic                  out_valid,
   input  logic                  out_stall,
   output sxfr_pkg::report_type  out_item
);

   logic                 valid_ff, valid_in;
   sxfr_pkg::report_type item_ff;
   logic                 load;

   // register is free when empty or its report is taken this cycle
   assign load     = !valid_ff || !out_stall;
   assign q_pop    = load && q_not_empty;
   assign valid_in = load ? q_not_empty : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
